@@ hw/rtl/row_three_tap_smoothing_filter_core_macros.svh @@
// Assertion macros of the row smoothing filter RTL.
`ifndef ROW_THREE_TAP_SMOOTHING_FILTER_CORE_MACROS_SVH
`define ROW_THREE_TAP_SMOOTHING_FILTER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define RTSF_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("rtsf assertion failed");
`define RTSF_ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("rtsf forbidden condition seen");
`else
`define RTSF_ASSERT(label, clk, rst, prop)
`define RTSF_ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

@@ hw/rtl/rtsf_pkg.sv @@
// Types and constants of the row smoothing filter.
package rtsf_pkg;

   // register file
   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_COEF_LEFT   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COEF_CENTRE = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_COEF_RIGHT  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_NORM_SCALE  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_WIDTH   = 3'd4;

   // field widths
   localparam int PIXEL_W     = 8;
   localparam int COEF_W      = 16;
   localparam int SCALE_W     = 24;
   localparam int ROW_WIDTH_W = 13;
   localparam int VALUE_W     = 16;
   localparam int PROD_W      = PIXEL_W + COEF_W;
   localparam int ACC_W       = PROD_W + 2;
   localparam int SCALED_W    = ACC_W + SCALE_W;
   localparam int ROUND_SHIFT = 16;
   localparam int ROUNDED_W   = SCALED_W - ROUND_SHIFT + 1;

   // reset values
   localparam logic [COEF_W-1:0]      COEF_LEFT_RST   = 16'd256;
   localparam logic [COEF_W-1:0]      COEF_CENTRE_RST = 16'd512;
   localparam logic [COEF_W-1:0]      COEF_RIGHT_RST  = 16'd256;
   localparam logic [SCALE_W-1:0]     NORM_SCALE_RST  = 24'd16384;
   localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RST   = 13'd640;

   // queues
   localparam int JQ_DEPTH = 4;
   localparam int JQ_PTR_W = 2;
   localparam int JQ_CNT_W = 3;
   localparam int RQ_DEPTH = 4;
   localparam int RQ_PTR_W = 2;
   localparam int RQ_CNT_W = 3;

   // one filter job: three taps and the end-of-run flag
   typedef struct packed {
      logic [PIXEL_W-1:0] left;
      logic [PIXEL_W-1:0] centre;
      logic [PIXEL_W-1:0] right;
      logic               last;
   } job_type;

   // one finished result
   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               last;
   } result_type;

   typedef struct packed {
      logic [COEF_W-1:0]  coef_left;
      logic [COEF_W-1:0]  coef_centre;
      logic [COEF_W-1:0]  coef_right;
      logic [SCALE_W-1:0] norm_scale;
   } coef_type;

   typedef struct packed {
      logic full;
      logic empty;
   } jq_status_type;

   typedef struct packed {
      logic pending;
      logic split;
   } front_status_type;

   typedef struct packed {
      logic rq_write;
      logic rq_full;
   } back_status_type;

endpackage

@@ hw/rtl/rtsf_front.sv @@
// Front end: tracks row position and neighbors, turns pixels into filter jobs.
module rtsf_front #(
   parameter int MAX_ROW_WIDTH = 4096
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_push,
   input  logic [rtsf_pkg::PIXEL_W-1:0]         req_pixel,
   output logic                                 req_full,
   input  logic [rtsf_pkg::ROW_WIDTH_W-1:0]     row_width,
   input  rtsf_pkg::jq_status_type              jq_status,
   output logic                                 job_push,
   output rtsf_pkg::job_type                    job,
   output rtsf_pkg::front_status_type           status
);
   import rtsf_pkg::*;

   localparam int CW = $clog2(MAX_ROW_WIDTH);
   localparam int WW = (CW + 1 > ROW_WIDTH_W) ? CW + 1 : ROW_WIDTH_W;

   logic [PIXEL_W-1:0] prev_ff, prev_in;
   logic [PIXEL_W-1:0] prev_prev_ff, prev_prev_in;
   logic [CW-1:0]      col_ff, col_in;
   logic               pending_ff, pending_in;
   job_type            pending_job_ff, pending_job_in;

   logic [WW-1:0] rw_ext;
   logic [WW-1:0] w_eff;
   logic [WW-1:0] limit;
   logic          accept;
   logic          is_last;
   logic          has_left_job;
   job_type       job_first;
   job_type       job_second;

   // effective row width, clamped
   always_comb begin
      rw_ext = WW'(row_width);
      priority if (rw_ext < WW'(3)) begin
         w_eff = WW'(3);
      end else if (rw_ext > WW'(MAX_ROW_WIDTH)) begin
         w_eff = WW'(MAX_ROW_WIDTH);
      end else begin
         w_eff = rw_ext;
      end
      limit = w_eff - WW'(1);
   end

   assign req_full     = pending_ff | jq_status.full;
   assign accept       = req_push & ~req_full;
   assign is_last      = WW'(col_ff) >= limit;
   assign has_left_job = col_ff != '0;

   // job for the previous column, then the job for the row's last pixel
   always_comb begin
      job_first.left    = (col_ff > CW'(1)) ? prev_prev_ff : '0;
      job_first.centre  = prev_ff;
      job_first.right   = req_pixel;
      job_first.last    = ~is_last;
      job_second.left   = has_left_job ? prev_ff : '0;
      job_second.centre = req_pixel;
      job_second.right  = '0;
      job_second.last   = 1'b1;
   end

   // issue to the job queue; a split item parks its second job
   always_comb begin
      prev_in        = prev_ff;
      prev_prev_in   = prev_prev_ff;
      col_in         = col_ff;
      pending_in     = pending_ff;
      pending_job_in = pending_job_ff;
      job            = has_left_job ? job_first : job_second;
      job_push       = 1'b0;
      if (pending_ff) begin
         job      = pending_job_ff;
         job_push = ~jq_status.full;
         if (!jq_status.full) begin
            pending_in = 1'b0;
         end
      end else if (accept) begin
         job_push     = has_left_job | is_last;
         prev_prev_in = prev_ff;
         prev_in      = req_pixel;
         col_in       = is_last ? '0 : col_ff + CW'(1);
         if (has_left_job && is_last) begin
            pending_in     = 1'b1;
            pending_job_in = job_second;
         end
      end
   end

   assign status.pending = pending_ff;
   assign status.split   = accept & has_left_job & is_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff      <= '0;
         prev_prev_ff <= '0;
         col_ff       <= '0;
         pending_ff   <= 1'b0;
      end else begin
         prev_ff      <= prev_in;
         prev_prev_ff <= prev_prev_in;
         col_ff       <= col_in;
         pending_ff   <= pending_in;
      end
   end

   always_ff @(posedge clock) begin
      pending_job_ff <= pending_job_in;
   end

endmodule

@@ hw/rtl/rtsf_job_queue.sv @@
// Short job queue between the front end and the arithmetic back end.
module rtsf_job_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  rtsf_pkg::job_type       push_job,
   input  logic                    pop,
   output rtsf_pkg::job_type       head_job,
   output rtsf_pkg::jq_status_type status
);
   import rtsf_pkg::*;

   job_type               mem_ff [JQ_DEPTH];
   logic [JQ_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [JQ_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [JQ_CNT_W-1:0]   count_ff, count_in;
   logic                  do_push;
   logic                  do_pop;

   assign status.full  = count_ff == JQ_CNT_W'(JQ_DEPTH);
   assign status.empty = count_ff == '0;
   assign do_push      = push & ~status.full;
   assign do_pop       = pop & ~status.empty;
   assign head_job     = mem_ff[rd_ptr_ff];

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + JQ_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + JQ_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + JQ_CNT_W'(do_push) - JQ_CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

@@ hw/rtl/rtsf_back.sv @@
// Back end: weighted tap sum, scaling, rounding and the result queue.
module rtsf_back (
   input  logic                            clock,
   input  logic                            reset,
   input  rtsf_pkg::coef_type              coefs,
   input  rtsf_pkg::job_type               head_job,
   input  rtsf_pkg::jq_status_type         jq_status,
   output logic                            job_pop,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output logic [rtsf_pkg::VALUE_W-1:0]    rsp_out_value,
   output logic                            rsp_last_of_run,
   output rtsf_pkg::back_status_type       status
);
   import rtsf_pkg::*;

   // stage A: tap sum; stage B: scaled sum
   logic                  a_valid_ff, a_valid_in;
   logic [ACC_W-1:0]      a_acc_ff, a_acc_in;
   logic                  a_last_ff;
   logic                  b_valid_ff, b_valid_in;
   logic [SCALED_W-1:0]   b_scaled_ff, b_scaled_in;
   logic                  b_last_ff;

   result_type            rq_mem_ff [RQ_DEPTH];
   logic [RQ_PTR_W-1:0]   rq_wr_ff, rq_wr_in;
   logic [RQ_PTR_W-1:0]   rq_rd_ff, rq_rd_in;
   logic [RQ_CNT_W-1:0]   rq_count_ff, rq_count_in;
   logic [RQ_CNT_W-1:0]   committed;
   logic                  rq_read;
   logic [ROUNDED_W-1:0]  rounded;
   result_type            finished;

   // issue only when the result queue has room for everything in flight
   assign committed = rq_count_ff + RQ_CNT_W'(a_valid_ff) + RQ_CNT_W'(b_valid_ff);
   assign job_pop   = ~jq_status.empty & (committed < RQ_CNT_W'(RQ_DEPTH));

   // tap products and sum
   always_comb begin
      a_valid_in = job_pop;
      a_acc_in   = ACC_W'(PROD_W'(head_job.left) * PROD_W'(coefs.coef_left))
                 + ACC_W'(PROD_W'(head_job.centre) * PROD_W'(coefs.coef_centre))
                 + ACC_W'(PROD_W'(head_job.right) * PROD_W'(coefs.coef_right));
   end

   // normalize by the reciprocal of the weight sum
   always_comb begin
      b_valid_in  = a_valid_ff;
      b_scaled_in = SCALED_W'(a_acc_ff) * SCALED_W'(coefs.norm_scale);
   end

   // round half up to Q8.8 and saturate
   always_comb begin
      rounded = ROUNDED_W'(b_scaled_ff >> ROUND_SHIFT)
              + ROUNDED_W'(b_scaled_ff[ROUND_SHIFT-1]);
      finished.value = (rounded[ROUNDED_W-1:VALUE_W] != '0) ? '1 : rounded[VALUE_W-1:0];
      finished.last  = b_last_ff;
   end

   // result queue
   assign rsp_empty       = rq_count_ff == '0;
   assign rq_read         = rsp_pop & ~rsp_empty;
   assign rsp_out_value   = rq_mem_ff[rq_rd_ff].value;
   assign rsp_last_of_run = rq_mem_ff[rq_rd_ff].last;
   assign status.rq_write = b_valid_ff;
   assign status.rq_full  = rq_count_ff == RQ_CNT_W'(RQ_DEPTH);

   always_comb begin
      rq_wr_in    = b_valid_ff ? rq_wr_ff + RQ_PTR_W'(1) : rq_wr_ff;
      rq_rd_in    = rq_read ? rq_rd_ff + RQ_PTR_W'(1) : rq_rd_ff;
      rq_count_in = rq_count_ff + RQ_CNT_W'(b_valid_ff) - RQ_CNT_W'(rq_read);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff  <= 1'b0;
         b_valid_ff  <= 1'b0;
         rq_wr_ff    <= '0;
         rq_rd_ff    <= '0;
         rq_count_ff <= '0;
      end else begin
         a_valid_ff  <= a_valid_in;
         b_valid_ff  <= b_valid_in;
         rq_wr_ff    <= rq_wr_in;
         rq_rd_ff    <= rq_rd_in;
         rq_count_ff <= rq_count_in;
      end
   end

   // payload pipeline
   always_ff @(posedge clock) begin
      a_acc_ff    <= a_acc_in;
      a_last_ff   <= head_job.last;
      b_scaled_ff <= b_scaled_in;
      b_last_ff   <= a_last_ff;
      if (b_valid_ff) begin
         rq_mem_ff[rq_wr_ff] <= finished;
      end
   end

endmodule

@@ hw/rtl/row_three_tap_smoothing_filter_core.sv @@
// Top level of the horizontal three-tap row smoothing filter.
//
//   channel  ports       handshake                  carries
//   input    req_*       push / full                one pixel
//   result   rsp_*       pop / empty                filtered value, end-of-run flag
//   config   csr_*       APB, pready tied 1         coefficients, scale, row width
//
// Takes one pixel per cycle while full is low; the last pixel of a row that has a left
// neighbor holds the input while its second job is issued.
// A result passes the job queue, stage A, stage B and the result queue to the rsp_ ports.
// Synchronous reset clears row position, neighbors, queues and loads register defaults.
// A result queue of four items absorbs output stalls; the back end issues a job only
// when that queue has room for it and everything in flight, then the job queue fills
// and full rises.
module row_three_tap_smoothing_filter_core #(
   parameter int MAX_ROW_WIDTH = 4096
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_push,
   output logic                               req_full,
   input  logic [rtsf_pkg::PIXEL_W-1:0]       req_pixel,
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output logic [rtsf_pkg::VALUE_W-1:0]       rsp_out_value,
   output logic                               rsp_last_of_run,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [rtsf_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [rtsf_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [rtsf_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready
);
   import rtsf_pkg::*;

`include "row_three_tap_smoothing_filter_core_macros.svh"

   logic [COEF_W-1:0]      coef_left_ff, coef_left_in;
   logic [COEF_W-1:0]      coef_centre_ff, coef_centre_in;
   logic [COEF_W-1:0]      coef_right_ff, coef_right_in;
   logic [SCALE_W-1:0]     norm_scale_ff, norm_scale_in;
   logic [ROW_WIDTH_W-1:0] row_width_ff, row_width_in;

   logic                   csr_write;
   logic [CSR_INDEX_W-1:0] csr_index;
   coef_type               coefs;
   job_type                front_job;
   job_type                head_job;
   logic                   job_push;
   logic                   job_pop;
   jq_status_type          jq_status;
   front_status_type       front_status;
   back_status_type        back_status;

   // register file
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_index  = csr_paddr[CSR_ADDR_W-1:2];

   always_comb begin
      coef_left_in   = coef_left_ff;
      coef_centre_in = coef_centre_ff;
      coef_right_in  = coef_right_ff;
      norm_scale_in  = norm_scale_ff;
      row_width_in   = row_width_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_COEF_LEFT:   coef_left_in   = csr_pwdata[COEF_W-1:0];
            CSR_COEF_CENTRE: coef_centre_in = csr_pwdata[COEF_W-1:0];
            CSR_COEF_RIGHT:  coef_right_in  = csr_pwdata[COEF_W-1:0];
            CSR_NORM_SCALE:  norm_scale_in  = csr_pwdata[SCALE_W-1:0];
            CSR_ROW_WIDTH:   row_width_in   = csr_pwdata[ROW_WIDTH_W-1:0];
            default: ;
         endcase
      end
   end

   // read back
   always_comb begin
      unique case (csr_index)
         CSR_COEF_LEFT:   csr_prdata = CSR_DATA_W'(coef_left_ff);
         CSR_COEF_CENTRE: csr_prdata = CSR_DATA_W'(coef_centre_ff);
         CSR_COEF_RIGHT:  csr_prdata = CSR_DATA_W'(coef_right_ff);
         CSR_NORM_SCALE:  csr_prdata = CSR_DATA_W'(norm_scale_ff);
         CSR_ROW_WIDTH:   csr_prdata = CSR_DATA_W'(row_width_ff);
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_left_ff   <= COEF_LEFT_RST;
         coef_centre_ff <= COEF_CENTRE_RST;
         coef_right_ff  <= COEF_RIGHT_RST;
         norm_scale_ff  <= NORM_SCALE_RST;
         row_width_ff   <= ROW_WIDTH_RST;
      end else begin
         coef_left_ff   <= coef_left_in;
         coef_centre_ff <= coef_centre_in;
         coef_right_ff  <= coef_right_in;
         norm_scale_ff  <= norm_scale_in;
         row_width_ff   <= row_width_in;
      end
   end

   assign coefs.coef_left   = coef_left_ff;
   assign coefs.coef_centre = coef_centre_ff;
   assign coefs.coef_right  = coef_right_ff;
   assign coefs.norm_scale  = norm_scale_ff;

   rtsf_front #(
      .MAX_ROW_WIDTH (MAX_ROW_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_pixel (req_pixel),
      .req_full  (req_full),
      .row_width (row_width_ff),
      .jq_status (jq_status),
      .job_push  (job_push),
      .job       (front_job),
      .status    (front_status)
   );

   rtsf_job_queue u_job_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (front_job),
      .pop      (job_pop),
      .head_job (head_job),
      .status   (jq_status)
   );

   rtsf_back u_back (
      .clock           (clock),
      .reset           (reset),
      .coefs           (coefs),
      .head_job        (head_job),
      .jq_status       (jq_status),
      .job_pop         (job_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_out_value   (rsp_out_value),
      .rsp_last_of_run (rsp_last_of_run),
      .status          (back_status)
   );

   // checks
   `RTSF_ASSERT_NEVER(a_job_overflow, clock, reset, job_push && jq_status.full)
   `RTSF_ASSERT_NEVER(a_result_overflow, clock, reset, back_status.rq_write && back_status.rq_full)
   `RTSF_ASSERT(a_split_holds_input, clock, reset, front_status.split |=> req_full)
   `RTSF_ASSERT_NEVER(a_issue_empty_queue, clock, reset, job_pop && jq_status.empty)

endmodule

@@ tb/row_three_tap_smoothing_filter_core_test.sv @@
// Self-checking testbench of the row three-tap smoothing filter core.
module row_three_tap_smoothing_filter_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   import rtsf_pkg::*;

   localparam int ROW_MAX = 4096;
   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE_CYCLES = 20;
   localparam int RANDOM_ITEMS = 110;
   localparam int WIDE_ITEMS = 50;
   localparam int PREDICT = -1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_FIRST = CSR_INDEX_W'(CSR_ROW_WIDTH + 1);
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LAST = '1;

   typedef enum logic {PLAN_PIXEL, PLAN_CSR} plan_kind_type;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               last;
   } smooth_result_type;

   // one directed step: a pixel, with or without typed results, or a register write
   typedef struct {
      plan_kind_type            kind;
      logic [CSR_INDEX_W-1:0]   index;
      logic [CSR_DATA_W-1:0]    data;
      int                       typed_n;
      smooth_result_type        typed[2];
   } plan_row_type;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_push;
   logic                     req_full;
   logic [PIXEL_W-1:0]       req_pixel;
   logic                     rsp_empty;
   logic                     rsp_pop;
   logic [VALUE_W-1:0]       rsp_out_value;
   logic                     rsp_last_of_run;
   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_ADDR_W-1:0]    csr_paddr;
   logic [CSR_DATA_W-1:0]    csr_pwdata;
   logic [CSR_DATA_W-1:0]    csr_prdata;
   logic                     csr_pready;

   // predictor copy of registers and row state
   logic [COEF_W-1:0]        weight_left;
   logic [COEF_W-1:0]        weight_centre;
   logic [COEF_W-1:0]        weight_right;
   logic [SCALE_W-1:0]       norm_recip;
   logic [ROW_WIDTH_W-1:0]   row_len;
   logic [PIXEL_W-1:0]       last_px;
   logic [PIXEL_W-1:0]       older_px;
   int                       column;

   smooth_result_type        fresh[2];
   int                       fresh_n;
   smooth_result_type        smooth_due[$];
   plan_row_type             plan[$];

   int                       send_idle_pct;
   int                       recv_idle_pct;
   int                       hold_left;
   int                       errors;
   int                       items_sent;
   int                       results_checked;
   int                       cycle_count;

   row_three_tap_smoothing_filter_core #(
      .MAX_ROW_WIDTH(ROW_MAX)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_pixel(req_pixel),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_out_value(rsp_out_value),
      .rsp_last_of_run(rsp_last_of_run),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $time);
      errors++;
   endtask

   // weighted sum of three taps, scaled, rounded half up to Q8.8, saturated
   function automatic logic [VALUE_W-1:0] weigh_taps(input logic [PIXEL_W-1:0] l,
                                                      input logic [PIXEL_W-1:0] c,
                                                      input logic [PIXEL_W-1:0] r);
      logic [63:0] acc;
      logic [63:0] rounded;
      acc = 64'(l) * 64'(weight_left) + 64'(c) * 64'(weight_centre)
          + 64'(r) * 64'(weight_right);
      rounded = (acc * 64'(norm_recip) + (64'd1 << 15)) >> 16;
      return (rounded > 64'hFFFF) ? '1 : rounded[VALUE_W-1:0];
   endfunction

   // advance the row state by one pixel; results land in fresh[0 .. fresh_n-1]
   task automatic smooth_pixel(input logic [PIXEL_W-1:0] px);
      int  w;
      bit  row_end;
      logic [PIXEL_W-1:0] l;
      w = row_len;
      if (w < 3) w = 3;
      if (w > ROW_MAX) w = ROW_MAX;
      row_end = (column >= w - 1);
      fresh_n = 0;
      if (column > 0) begin
         l = (column > 1) ? older_px : '0;
         fresh[0].value = weigh_taps(l, last_px, px);
         fresh[0].last = !row_end;
         fresh_n = 1;
      end
      if (row_end) begin
         l = (column > 0) ? last_px : '0;
         fresh[fresh_n].value = weigh_taps(l, px, '0);
         fresh[fresh_n].last = 1'b1;
         fresh_n++;
      end
      older_px = last_px;
      last_px = px;
      column = row_end ? 0 : column + 1;
   endtask

   function automatic logic [CSR_DATA_W-1:0] register_value(input logic [CSR_INDEX_W-1:0] idx);
      case (idx)
         CSR_COEF_LEFT:   return CSR_DATA_W'(weight_left);
         CSR_COEF_CENTRE: return CSR_DATA_W'(weight_centre);
         CSR_COEF_RIGHT:  return CSR_DATA_W'(weight_right);
         CSR_NORM_SCALE:  return CSR_DATA_W'(norm_recip);
         CSR_ROW_WIDTH:   return CSR_DATA_W'(row_len);
         default:         return '0;
      endcase
   endfunction

   // APB setup and access cycles; a write also updates the predictor's copy
   task automatic csr_access(input bit wr, input logic [CSR_INDEX_W-1:0] idx,
                             input logic [CSR_DATA_W-1:0] wdata,
                             output logic [CSR_DATA_W-1:0] rdata);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= wr;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rdata = csr_prdata;
      if (wr) begin
         case (idx)
            CSR_COEF_LEFT:   weight_left = wdata[COEF_W-1:0];
            CSR_COEF_CENTRE: weight_centre = wdata[COEF_W-1:0];
            CSR_COEF_RIGHT:  weight_right = wdata[COEF_W-1:0];
            CSR_NORM_SCALE:  norm_recip = wdata[SCALE_W-1:0];
            CSR_ROW_WIDTH:   row_len = wdata[ROW_WIDTH_W-1:0];
            default: ;
         endcase
      end
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      logic [CSR_DATA_W-1:0] unused;
      csr_access(1'b1, idx, data, unused);
   endtask

   task automatic check_registers();
      logic [CSR_DATA_W-1:0] got;
      for (int i = CSR_COEF_LEFT; i <= CSR_ROW_WIDTH; i++) begin
         csr_access(1'b0, CSR_INDEX_W'(i), '0, got);
         if (got !== register_value(CSR_INDEX_W'(i)))
            report_mismatch($sformatf("register %0d readback", i), got,
                            register_value(CSR_INDEX_W'(i)));
      end
   endtask

   // stop offering, wait for every expected result, then let the pipe settle
   task automatic wait_drained();
      @(negedge clock);
      req_push <= 1'b0;
      while (smooth_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // offer one pixel, predict at the accepting edge
   task automatic send_pixel(input plan_row_type row);
      int gap;
      if ($urandom_range(99) < send_idle_pct) begin
         gap = $urandom_range(1, 3);
         repeat (gap) begin
            @(negedge clock);
            req_push <= 1'b0;
         end
      end
      @(negedge clock);
      req_push <= 1'b1;
      req_pixel <= row.data[PIXEL_W-1:0];
      @(posedge clock);
      while (req_full) @(posedge clock);
      smooth_pixel(row.data[PIXEL_W-1:0]);
      items_sent++;
      if (row.typed_n == PREDICT) begin
         for (int i = 0; i < fresh_n; i++) smooth_due.insert(smooth_due.size(), fresh[i]);
      end else begin
         for (int i = 0; i < row.typed_n; i++)
            smooth_due.insert(smooth_due.size(), row.typed[i]);
      end
   endtask

   task automatic send_random(input int count);
      plan_row_type row;
      row.kind = PLAN_PIXEL;
      row.typed_n = PREDICT;
      repeat (count) begin
         case ($urandom_range(0, 7))
            0:       row.data = 0;
            1:       row.data = 255;
            default: row.data = $urandom_range(0, 255);
         endcase
         send_pixel(row);
      end
   endtask

   task automatic add_px(input int px, input int n = PREDICT,
                         input int v0 = 0, input bit l0 = 0,
                         input int v1 = 0, input bit l1 = 0);
      plan_row_type row;
      row.kind = PLAN_PIXEL;
      row.index = '0;
      row.data = px;
      row.typed_n = n;
      row.typed[0] = '{value: VALUE_W'(v0), last: l0};
      row.typed[1] = '{value: VALUE_W'(v1), last: l1};
      plan.insert(plan.size(), row);
   endtask

   task automatic add_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      plan_row_type row;
      row.kind = PLAN_CSR;
      row.index = idx;
      row.data = data;
      row.typed_n = 0;
      row.typed[0] = '0;
      row.typed[1] = '0;
      plan.insert(plan.size(), row);
   endtask

   // random register set; narrow ranges let part of the results stay below saturation
   task automatic random_setup(input bit full_range);
      if (full_range) begin
         csr_write(CSR_COEF_LEFT, $urandom());
         csr_write(CSR_COEF_CENTRE, $urandom());
         csr_write(CSR_COEF_RIGHT, $urandom());
         csr_write(CSR_NORM_SCALE, $urandom());
      end else begin
         csr_write(CSR_COEF_LEFT, $urandom_range(0, 1023));
         csr_write(CSR_COEF_CENTRE, $urandom_range(0, 1023));
         csr_write(CSR_COEF_RIGHT, $urandom_range(0, 1023));
         csr_write(CSR_NORM_SCALE, $urandom_range(0, 65535));
      end
      case ($urandom_range(0, 3))
         0:       csr_write(CSR_ROW_WIDTH, $urandom_range(0, 2));
         3:       csr_write(CSR_ROW_WIDTH, $urandom_range(10, 40));
         default: csr_write(CSR_ROW_WIDTH, $urandom_range(3, 9));
      endcase
      check_registers();
   endtask

   // receiver: random pop, or a counted hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // result checker
   always @(posedge clock) begin : result_check
      smooth_result_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (smooth_due.size() == 0) begin
            report_mismatch("result with none expected", rsp_out_value, -1);
         end else begin
            want = smooth_due.pop_front();
            results_checked++;
            if (rsp_out_value !== want.value)
               report_mismatch("out_value", rsp_out_value, want.value);
            if (rsp_last_of_run !== want.last)
               report_mismatch("last_of_run", rsp_last_of_run, want.last);
         end
      end
   end

   // watchdog
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               smooth_due.size());
      $display("[row_three_tap_smoothing_filter_core] ERROR");
      $finish;
   end

   initial begin
      reset = 1'b1;
      req_push = 1'b0;
      req_pixel = '0;
      rsp_pop = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      hold_left = 0;
      errors = 0;
      items_sent = 0;
      results_checked = 0;
      weight_left = COEF_LEFT_RST;
      weight_centre = COEF_CENTRE_RST;
      weight_right = COEF_RIGHT_RST;
      norm_recip = NORM_SCALE_RST;
      row_len = ROW_WIDTH_RST;
      last_px = '0;
      older_px = '0;
      column = 0;

      // directed steps; reset defaults first, 640-wide rows
      add_px(255, 0);
      add_px(255, 1, 48960, 1);
      // shrink the row under the current column: next pixel ends the row
      add_csr(CSR_ROW_WIDTH, 3);
      add_px(255, 2, 65280, 0, 48960, 1);
      add_px(0, 0);
      add_px(0, 1, 0, 1);
      add_px(0, 2, 0, 0, 0, 1);
      // all-ones writes, masked to width: full saturation
      add_csr(CSR_COEF_LEFT, '1);
      add_csr(CSR_COEF_CENTRE, '1);
      add_csr(CSR_COEF_RIGHT, '1);
      add_csr(CSR_NORM_SCALE, '1);
      add_px(255, 0);
      add_px(255, 1, 65535, 1);
      add_px(255, 2, 65535, 0, 65535, 1);
      add_px(0, 0);
      add_px(0, 1, 0, 1);
      add_px(0, 2, 0, 0, 0, 1);
      add_px(8'h55);
      add_px(8'hAA);
      add_px(8'h01);
      // zero weights
      add_csr(CSR_COEF_LEFT, 0);
      add_csr(CSR_COEF_CENTRE, 0);
      add_csr(CSR_COEF_RIGHT, 0);
      add_px(255, 0);
      add_px(255, 1, 0, 1);
      add_px(255, 2, 0, 0, 0, 1);
      // zero scale
      add_csr(CSR_COEF_LEFT, COEF_LEFT_RST);
      add_csr(CSR_COEF_CENTRE, COEF_CENTRE_RST);
      add_csr(CSR_COEF_RIGHT, COEF_RIGHT_RST);
      add_csr(CSR_NORM_SCALE, 0);
      add_px(170, 0);
      add_px(170, 1, 0, 1);
      add_px(170, 2, 0, 0, 0, 1);
      // undersized row widths clamp to three; spare addresses are ignored
      add_csr(CSR_NORM_SCALE, NORM_SCALE_RST);
      add_csr(CSR_ROW_WIDTH, 2);
      for (int i = CSR_SPARE_FIRST; i <= CSR_SPARE_LAST; i++)
         add_csr(CSR_INDEX_W'(i), '1);
      add_px(10);
      add_px(20);
      add_px(30);
      add_csr(CSR_ROW_WIDTH, 0);
      add_px(40);
      add_px(50);
      add_px(60);

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 27;
      recv_idle_pct = 60;
      foreach (plan[i]) begin
         if (plan[i].kind == PLAN_CSR) begin
            wait_drained();
            csr_write(plan[i].index, plan[i].data);
         end else begin
            send_pixel(plan[i]);
         end
      end
      wait_drained();
      check_registers();

      // random phases: receiver-heavy idling, sender-heavy idling, none
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 27 : (phase == 1) ? 60 : 0;
         recv_idle_pct = (phase == 0) ? 60 : (phase == 1) ? 27 : 0;
         random_setup(phase == 1);
         // long receiver stall while pixels keep coming: fills the block
         if (phase == 0) hold_left = 200;
         send_random(RANDOM_ITEMS);
         wait_drained();
      end

      // oversized width clamps to the maximum: no row end within these pixels
      random_setup(1'b0);
      csr_write(CSR_ROW_WIDTH, '1);
      check_registers();
      send_random(WIDE_ITEMS);
      wait_drained();

      $display("covered %0d pixels and %0d results: directed edges, three idling phases,",
               items_sent, results_checked);
      $display("a receiver stall that filled the block, and a row width clamped to %0d",
               ROW_MAX);
      if (errors == 0) begin
         $display("[row_three_tap_smoothing_filter_core] OK");
      end else begin
         $display("[row_three_tap_smoothing_filter_core] ERROR");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/rtsf_pkg.sv
hw/rtl/rtsf_front.sv
hw/rtl/rtsf_job_queue.sv
hw/rtl/rtsf_back.sv
hw/rtl/row_three_tap_smoothing_filter_core.sv
tb/row_three_tap_smoothing_filter_core_test.sv
